/* src/signal_voter_alloc_and_vote_unit_assert.svh */
// Assertion macros for the voting unit. Empty under synthesis.
`ifndef SIGNAL_VOTER_ALLOC_AND_VOTE_UNIT_ASSERT_SVH
`define SIGNAL_VOTER_ALLOC_AND_VOTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SVAV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SVAV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SVAV_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SVAV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/svav_pkg.sv */
package svav_pkg;

  localparam int HANDLE_W = 8;

  typedef logic [1:0] opcode_t;
  typedef logic [2:0] sig_sel_t;

  localparam opcode_t OP_ALLOC   = 2'd0;
  localparam opcode_t OP_RELEASE = 2'd1;
  localparam opcode_t OP_VOTE    = 2'd2;
  localparam opcode_t OP_ACK     = 2'd3;

  localparam sig_sel_t SEL_IRQ = 3'd0;
  localparam sig_sel_t SEL_NMI = 3'd1;
  localparam sig_sel_t SEL_RDY = 3'd2;
  localparam sig_sel_t SEL_BE  = 3'd3;

endpackage

/* src/svav_alloc.sv */
// Lowest-free-bit finder: isolate the lowest zero bit of the allocation mask.
module svav_alloc #(
  parameter int VOTER_COUNT = 8
) (
  input  logic [VOTER_COUNT-1:0] alloc_mask,
  output logic [VOTER_COUNT-1:0] grant
);

  logic [VOTER_COUNT-1:0] mask_inc;

  // All ones wraps to zero, so a full mask grants nothing.
  assign mask_inc = alloc_mask + VOTER_COUNT'(1);
  assign grant    = ~alloc_mask & mask_inc;

endmodule

/* src/signal_voter_alloc_and_vote_unit.sv */
// Throughput: one beat per cycle; input register, one logic stage, result register.
// busy is high during reset and in the cycle after it is released; otherwise low.
// Reset (rst_n, synchronous, active low) clears all voter and vote masks and the
// NMI edge flag. Results are strobed for one cycle; the receiver cannot stall.
`include "signal_voter_alloc_and_vote_unit_assert.svh"
module signal_voter_alloc_and_vote_unit
  import svav_pkg::*;
#(
  parameter int VOTER_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  opcode_t             in_opcode,
  input  logic [HANDLE_W-1:0] in_voter_mask,
  input  sig_sel_t            in_signal_select,
  input  logic                in_take_vote,
  output logic                out_valid,
  output logic [HANDLE_W-1:0] out_new_handle,
  output logic                out_irq_active,
  output logic                out_nmi_active,
  output logic                out_rdy_active,
  output logic                out_be_active,
  output logic                out_nmi_edge_flag
);

  // Width that holds both a port handle and a voter mask.
  localparam int WideW = (VOTER_COUNT > HANDLE_W) ? VOTER_COUNT : HANDLE_W;

  logic busy_r;
  logic accept;

  // Input register (one beat).
  logic                stg_valid_r;
  opcode_t             stg_op_r;
  logic [HANDLE_W-1:0] stg_mask_r;
  sig_sel_t            stg_sel_r;
  logic                stg_take_r;

  // Voting state.
  logic [VOTER_COUNT-1:0] alloc_r, alloc_nxt;
  logic [VOTER_COUNT-1:0] irq_r, irq_nxt;
  logic [VOTER_COUNT-1:0] nmi_r, nmi_nxt;
  logic [VOTER_COUNT-1:0] rdy_r, rdy_nxt;
  logic [VOTER_COUNT-1:0] be_r, be_nxt;
  logic                   nmi_edge_r, nmi_edge_nxt;

  // Result register.
  logic                out_valid_r;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_irq_r, out_nmi_r, out_rdy_r, out_be_r, out_edge_r;

  logic [WideW-1:0]       mask_wide;
  logic [VOTER_COUNT-1:0] handle;
  logic [VOTER_COUNT-1:0] grant;
  logic [WideW-1:0]       grant_wide;
  logic                   hit;

  // Hold busy while reset is asserted and in the cycle after it is released.
  assign busy   = busy_r || !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // Capture the incoming beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_op_r   <= in_opcode;
      stg_mask_r <= in_voter_mask;
      stg_sel_r  <= in_signal_select;
      stg_take_r <= in_take_vote;
    end
  end

  // Drop handle bits beyond the voter count.
  assign mask_wide = WideW'(stg_mask_r);
  assign handle    = mask_wide[VOTER_COUNT-1:0];
  assign hit       = |(alloc_r & handle);

  svav_alloc #(
    .VOTER_COUNT(VOTER_COUNT)
  ) u_alloc (
    .alloc_mask(alloc_r),
    .grant     (grant)
  );

  assign grant_wide = WideW'(grant);

  always_comb begin
    alloc_nxt      = alloc_r;
    irq_nxt        = irq_r;
    nmi_nxt        = nmi_r;
    rdy_nxt        = rdy_r;
    be_nxt         = be_r;
    nmi_edge_nxt   = nmi_edge_r;
    out_handle_nxt = '0;
    if (stg_valid_r) begin
      unique case (stg_op_r)
        OP_ALLOC: begin
          alloc_nxt      = alloc_r | grant;
          out_handle_nxt = grant_wide[HANDLE_W-1:0];
        end
        OP_RELEASE: begin
          alloc_nxt = alloc_r & ~handle;
        end
        OP_VOTE: begin
          // Ignore the vote unless the handle touches an allocated voter.
          if (hit) begin
            case (stg_sel_r)
              SEL_IRQ: irq_nxt = stg_take_r ? (irq_r | handle) : (irq_r & ~handle);
              SEL_NMI: begin
                nmi_nxt = stg_take_r ? (nmi_r | handle) : (nmi_r & ~handle);
                if (stg_take_r && nmi_r == '0) begin
                  nmi_edge_nxt = 1'b1;
                end
              end
              SEL_RDY: rdy_nxt = stg_take_r ? (rdy_r | handle) : (rdy_r & ~handle);
              SEL_BE:  be_nxt  = stg_take_r ? (be_r | handle) : (be_r & ~handle);
              default: ;
            endcase
          end
        end
        OP_ACK: begin
          nmi_edge_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r     <= '0;
      irq_r       <= '0;
      nmi_r       <= '0;
      rdy_r       <= '0;
      be_r        <= '0;
      nmi_edge_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      alloc_r     <= alloc_nxt;
      irq_r       <= irq_nxt;
      nmi_r       <= nmi_nxt;
      rdy_r       <= rdy_nxt;
      be_r        <= be_nxt;
      nmi_edge_r  <= nmi_edge_nxt;
      out_valid_r <= stg_valid_r;
    end
  end

  // Result shows the state after the beat.
  always_ff @(posedge clk) begin
    if (stg_valid_r) begin
      out_handle_r <= out_handle_nxt;
      out_irq_r    <= |irq_nxt;
      out_nmi_r    <= |nmi_nxt;
      out_rdy_r    <= |rdy_nxt;
      out_be_r     <= |be_nxt;
      out_edge_r   <= nmi_edge_nxt;
    end
  end

  // Drop the strobe while reset is asserted.
  assign out_valid         = out_valid_r && rst_n;
  assign out_new_handle    = out_handle_r;
  assign out_irq_active    = out_irq_r;
  assign out_nmi_active    = out_nmi_r;
  assign out_rdy_active    = out_rdy_r;
  assign out_be_active     = out_be_r;
  assign out_nmi_edge_flag = out_edge_r;

  `SVAV_ASSERT_NOW(a_handle_onehot, clk, rst_n, out_valid_r, $onehot0(out_handle_r))
  `SVAV_ASSERT_NEXT(a_handle_only_alloc, clk, rst_n, stg_valid_r && stg_op_r != OP_ALLOC, out_handle_r == '0)
  `SVAV_ASSERT_NEXT(a_grant_marked, clk, rst_n, stg_valid_r && stg_op_r == OP_ALLOC, (alloc_r & $past(grant)) == $past(grant))
  `SVAV_ASSERT_NOW(a_grant_free, clk, rst_n, grant != '0, (alloc_r & grant) == '0)
  `SVAV_ASSERT_NEXT(a_ack_clears, clk, rst_n, stg_valid_r && stg_op_r == OP_ACK, !nmi_edge_r && !out_edge_r)
  `SVAV_ASSERT_NEXT(a_one_result, clk, rst_n, stg_valid_r, out_valid_r)

endmodule

/* sim/signal_voter_checker.sv */
module signal_voter_checker
  import svav_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  opcode_t             in_opcode,
  input  logic [HANDLE_W-1:0] in_voter_mask,
  input  sig_sel_t            in_signal_select,
  input  logic                in_take_vote,
  input  logic                out_valid,
  input  logic [HANDLE_W-1:0] out_new_handle,
  input  logic                out_irq_active,
  input  logic                out_nmi_active,
  input  logic                out_rdy_active,
  input  logic                out_be_active,
  input  logic                out_nmi_edge_flag,
  output int                  fail_count,
  output int                  pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOTERS = 8;

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic                irq;
    logic                nmi;
    logic                rdy;
    logic                be;
    logic                nmi_edge;
  } line_status_t;

  // Shadow of the unit's voter bookkeeping
  logic [VOTERS-1:0] owned_voters;
  logic [VOTERS-1:0] irq_holders;
  logic [VOTERS-1:0] nmi_holders;
  logic [VOTERS-1:0] rdy_holders;
  logic [VOTERS-1:0] be_holders;
  logic              nmi_edge_latched;

  line_status_t expected_status[$];
  int           mismatches = 0;
  int           waiting = 0;

  assign fail_count      = mismatches;
  assign pending_results = waiting;

  function automatic logic [VOTERS-1:0] cast_on(logic [VOTERS-1:0] holders,
                                                logic [VOTERS-1:0] handle,
                                                logic take);
    return take ? (holders | handle) : (holders & ~handle);
  endfunction

  // Apply one request to the shadow state and return the status it produces.
  function automatic line_status_t apply_bus_request(opcode_t op, logic [HANDLE_W-1:0] mask,
                                                     sig_sel_t sel, logic take);
    line_status_t      st;
    logic [VOTERS-1:0] handle;
    logic              found;
    st = '0;
    handle = mask[VOTERS-1:0];
    found = 1'b0;
    case (op)
      OP_ALLOC: begin
        for (int i = 0; i < VOTERS; i++) begin
          if (!found && !owned_voters[i]) begin
            found = 1'b1;
            owned_voters[i] = 1'b1;
            st.new_handle = HANDLE_W'(1) << i;
          end
        end
      end
      OP_RELEASE: owned_voters = owned_voters & ~handle;
      OP_VOTE: begin
        if ((owned_voters & handle) != '0) begin
          case (sel)
            SEL_IRQ: irq_holders = cast_on(irq_holders, handle, take);
            SEL_NMI: begin
              if (take && nmi_holders == '0) nmi_edge_latched = 1'b1;
              nmi_holders = cast_on(nmi_holders, handle, take);
            end
            SEL_RDY: rdy_holders = cast_on(rdy_holders, handle, take);
            SEL_BE:  be_holders  = cast_on(be_holders, handle, take);
            default: ;
          endcase
        end
      end
      default: nmi_edge_latched = 1'b0;
    endcase
    st.irq      = irq_holders != '0;
    st.nmi      = nmi_holders != '0;
    st.rdy      = rdy_holders != '0;
    st.be       = be_holders != '0;
    st.nmi_edge = nmi_edge_latched;
    return st;
  endfunction

  task automatic check_field(string name, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    line_status_t want;
    if (!rst_n) begin
      owned_voters     = '0;
      irq_holders      = '0;
      nmi_holders      = '0;
      rdy_holders      = '0;
      be_holders       = '0;
      nmi_edge_latched = 1'b0;
      expected_status.delete();
    end else begin
      if (out_valid) begin
        if (expected_status.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("new_handle", want.new_handle, out_new_handle);
          check_field("irq_active", HANDLE_W'(want.irq), HANDLE_W'(out_irq_active));
          check_field("nmi_active", HANDLE_W'(want.nmi), HANDLE_W'(out_nmi_active));
          check_field("rdy_active", HANDLE_W'(want.rdy), HANDLE_W'(out_rdy_active));
          check_field("be_active", HANDLE_W'(want.be), HANDLE_W'(out_be_active));
          check_field("nmi_edge_flag", HANDLE_W'(want.nmi_edge),
                      HANDLE_W'(out_nmi_edge_flag));
        end
      end
      if (start && !busy)
        expected_status.push_back(apply_bus_request(in_opcode, in_voter_mask,
                                                    in_signal_select, in_take_vote));
    end
    waiting = expected_status.size();
  end

endmodule

/* sim/tb_signal_voter_alloc_and_vote_unit.sv */
module tb_signal_voter_alloc_and_vote_unit;
  import svav_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1350;
  localparam int DRAIN_CYCLES = 10;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  opcode_t             in_opcode;
  logic [HANDLE_W-1:0] in_voter_mask;
  sig_sel_t            in_signal_select;
  logic                in_take_vote;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_new_handle;
  logic                out_irq_active;
  logic                out_nmi_active;
  logic                out_rdy_active;
  logic                out_be_active;
  logic                out_nmi_edge_flag;
  int                  fail_count;
  int                  pending_results;

  // When set, the sender issues beats back to back with no idle cycles.
  bit                  gapless;

  signal_voter_alloc_and_vote_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_voter_mask    (in_voter_mask),
    .in_signal_select (in_signal_select),
    .in_take_vote     (in_take_vote),
    .out_valid        (out_valid),
    .out_new_handle   (out_new_handle),
    .out_irq_active   (out_irq_active),
    .out_nmi_active   (out_nmi_active),
    .out_rdy_active   (out_rdy_active),
    .out_be_active    (out_be_active),
    .out_nmi_edge_flag(out_nmi_edge_flag)
  );

  signal_voter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_voter_mask    (in_voter_mask),
    .in_signal_select (in_signal_select),
    .in_take_vote     (in_take_vote),
    .out_valid        (out_valid),
    .out_new_handle   (out_new_handle),
    .out_irq_active   (out_irq_active),
    .out_nmi_active   (out_nmi_active),
    .out_rdy_active   (out_rdy_active),
    .out_be_active    (out_be_active),
    .out_nmi_edge_flag(out_nmi_edge_flag),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Issue one request beat. Idle a random number of cycles first unless running
  // gapless, then hold start high until the unit takes the beat. Busy is sampled
  // at the falling edge, where it is settled to the value the next rising edge sees.
  // Start is left high after the beat so a gapless follow-up never toggles it
  // twice in one time step; the next gap or the end of stimulus lowers it.
  task automatic issue_request(opcode_t op, logic [HANDLE_W-1:0] mask,
                               sig_sel_t sel, logic take);
    int  idle;
    bit  taken;
    idle = gapless ? 0 : $urandom_range(0, 7);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_voter_mask    <= mask;
    in_signal_select <= sel;
    in_take_vote     <= take;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Pick a voter handle: mostly a single voter, sometimes an arbitrary mask,
  // now and then the empty or the full mask.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return HANDLE_W'(1) << $urandom_range(0, HANDLE_W - 1);
    if (roll < 92) return HANDLE_W'($urandom);
    if (roll < 96) return '0;
    return '1;
  endfunction

  // Mostly real bus lines, sometimes one of the ignored select codes.
  function automatic sig_sel_t pick_line();
    if ($urandom_range(0, 99) < 85) return sig_sel_t'($urandom_range(0, 3));
    return sig_sel_t'($urandom_range(4, 7));
  endfunction

  initial begin
    int roll;
    // Drive every input known before the first edge and hold reset.
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_opcode        <= OP_ALLOC;
    in_voter_mask    <= '0;
    in_signal_select <= SEL_IRQ;
    in_take_vote     <= 1'b0;
    gapless          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the corner cases in a fixed order.
    // Acknowledge with nothing pending, then a vote from a handle nobody owns.
    issue_request(OP_ACK, 8'h00, SEL_IRQ, 1'b0);
    issue_request(OP_VOTE, 8'h01, SEL_IRQ, 1'b1);
    // Claim all eight voters, then one more that must come back empty.
    repeat (9) issue_request(OP_ALLOC, 8'h00, SEL_IRQ, 1'b0);
    // First NMI vote latches the edge; a second while asserted leaves it alone.
    issue_request(OP_VOTE, 8'h01, SEL_NMI, 1'b1);
    issue_request(OP_ACK, 8'h00, SEL_NMI, 1'b0);
    issue_request(OP_VOTE, 8'h02, SEL_NMI, 1'b1);
    // Dropping all NMI votes never sets the edge.
    issue_request(OP_VOTE, 8'h03, SEL_NMI, 1'b0);
    // Raise the IRQ, RDY and BE lines, the full handle on IRQ.
    issue_request(OP_VOTE, 8'hFF, SEL_IRQ, 1'b1);
    issue_request(OP_VOTE, 8'h80, SEL_RDY, 1'b1);
    issue_request(OP_VOTE, 8'h40, SEL_BE, 1'b1);
    // Ignored select codes.
    issue_request(OP_VOTE, 8'hFF, 3'd7, 1'b0);
    issue_request(OP_VOTE, 8'hFF, 3'd4, 1'b0);
    // A released voter keeps its RDY vote and can no longer drop it.
    issue_request(OP_RELEASE, 8'h80, SEL_IRQ, 1'b0);
    issue_request(OP_VOTE, 8'h80, SEL_RDY, 1'b0);
    // A partly owned handle clears every one of its bits, owned or not.
    issue_request(OP_VOTE, 8'hC0, SEL_BE, 1'b0);
    // Release twice: the second hits bits already free.
    issue_request(OP_RELEASE, 8'h0F, SEL_IRQ, 1'b0);
    issue_request(OP_RELEASE, 8'h0F, SEL_IRQ, 1'b0);
    // Lowest free voter is handed out again.
    issue_request(OP_ALLOC, 8'h00, SEL_IRQ, 1'b0);
    issue_request(OP_VOTE, 8'h20, SEL_IRQ, 1'b0);

    // Random part: allocation churns against releases so handles keep hitting
    // owned voters; votes dominate. Switch between gapless and gappy stretches.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) gapless = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 22)
        issue_request(OP_ALLOC, HANDLE_W'($urandom), sig_sel_t'($urandom), 1'($urandom));
      else if (roll < 36)
        issue_request(OP_RELEASE, pick_handle(), sig_sel_t'($urandom), 1'($urandom));
      else if (roll < 88)
        issue_request(OP_VOTE, pick_handle(), pick_line(), $urandom_range(0, 99) < 60);
      else
        issue_request(OP_ACK, HANDLE_W'($urandom), sig_sel_t'($urandom), 1'($urandom));
    end
    start <= 1'b0;

    // Drain: wait for every result, then give stray beats a chance to show up.
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
